@@ hdl/ack_retransmit_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the retransmission queue
// Shorthand for clocked assertions on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRANSMIT_QUEUE_CORE_MACROS_SVH
`define ACK_RETRANSMIT_QUEUE_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define ARQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define ARQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/arq_pkg.sv @@
// ----------------------------------------------------------------------------
// Retransmission queue package
// Widths, codes, the table entry record, the result record and the states.
// ----------------------------------------------------------------------------
package arq_pkg;

	localparam int unsigned DEPTH_DEF              = 16;
	localparam int unsigned MESSAGE_RETRY_INTERVAL = 1000;
	localparam int unsigned MESSAGE_RETRY_ATTEMPTS = 3;

	localparam int unsigned ACTION_W   = 2;
	localparam int unsigned ID_W       = 8;
	localparam int unsigned REF_W      = 4;
	localparam int unsigned LEN_W      = 11;
	localparam int unsigned SEQ_W      = 32;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned INTERVAL_W = 16;
	localparam int unsigned LIMIT_W    = 8;
	localparam int unsigned ATT_W      = 8;
	localparam int unsigned KIND_W     = 3;
	localparam int unsigned COUNT_W    = 5;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_INTERVAL = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT    = 1'd1;

	localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ACK     = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PASS    = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ENQUEUED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ACK_MATCH = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ACK_MISS  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TRANSMIT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EVICTED   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PASS_DONE = 3'd5;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [ID_W-1:0]   dest;
		logic [REF_W-1:0]  slot;
		logic [LEN_W-1:0]  length;
		logic              once;
		logic [ATT_W-1:0]  attempts;
		logic [TIME_W-1:0] last_time;
	} rec_t;

	localparam int unsigned REC_W = $bits(rec_t);

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [SEQ_W-1:0]   seq;
		logic [ID_W-1:0]    dest;
		logic [REF_W-1:0]   slot_ref;
		logic [LEN_W-1:0]   length;
		logic               retired;
		logic               unreachable;
		logic [COUNT_W-1:0] sent_count;
		logic               last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DECIDE,
		ST_EVICT,
		ST_ENQ,
		ST_ACK_OUT,
		ST_PROC,
		ST_DONE
	} state_t;

endpackage

@@ hdl/arq_in_if.sv @@
// ----------------------------------------------------------------------------
// Retransmission queue command channel
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
interface arq_in_if;
	logic                          valid;
	logic                          ready;
	logic [arq_pkg::ACTION_W-1:0] action;
	logic [arq_pkg::ID_W-1:0]     recipient;
	logic [arq_pkg::REF_W-1:0]    payload_ref;
	logic [arq_pkg::LEN_W-1:0]    payload_len;
	logic                          single_shot;
	logic [arq_pkg::SEQ_W-1:0]    ack_seq;
	logic [arq_pkg::TIME_W-1:0]   now;

	modport source (
		output valid, action, recipient, payload_ref, payload_len, single_shot, ack_seq, now,
		input  ready
	);
	modport sink (
		input  valid, action, recipient, payload_ref, payload_len, single_shot, ack_seq, now,
		output ready
	);
endinterface

@@ hdl/arq_out_if.sv @@
// ----------------------------------------------------------------------------
// Retransmission queue result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface arq_out_if;
	logic                          valid;
	logic                          ready;
	logic [arq_pkg::KIND_W-1:0]   kind;
	logic [arq_pkg::SEQ_W-1:0]    seq;
	logic [arq_pkg::ID_W-1:0]     dest;
	logic [arq_pkg::REF_W-1:0]    slot_ref;
	logic [arq_pkg::LEN_W-1:0]    length;
	logic                          retired;
	logic                          unreachable;
	logic [arq_pkg::COUNT_W-1:0]  sent_count;
	logic                          last;

	modport source (
		output valid, kind, seq, dest, slot_ref, length, retired, unreachable, sent_count,
		       last,
		input  ready
	);
	modport sink (
		input  valid, kind, seq, dest, slot_ref, length, retired, unreachable, sent_count,
		       last,
		output ready
	);
endinterface

@@ hdl/arq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module arq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/ack_retransmit_queue_core.sv @@
// ----------------------------------------------------------------------------
// Acknowledged retransmission queue
// Holds outbound messages until acknowledged, resends them on retry passes
// and evicts the most-tried entry when the table is full.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake        Contents
// cmd       in         valid / ready    action, message fields, ack_seq, now
// res       out        valid / ready    kind, entry fields, flags, sent_count, last
// cfg       in         cfg_wen only     cfg_index selects the register, cfg_wdata
//
// Every enqueue, acknowledge or send pass runs a scan of the whole entry table, one
// entry per cycle, through a single age comparator fed by the registered read port
// of the entry RAM. An enqueue or acknowledge then decides and emits its result, with
// an eviction result first on a full table; a send pass rescans after each entry.
// Reset clears the valid bits, the sequence counter and the control state at once;
// the entry RAM itself is not cleared. A stalled result channel holds the sequencer
// in its emitting state; no command is taken until the current one is complete.
// ----------------------------------------------------------------------------
`include "ack_retransmit_queue_core_macros.svh"

module ack_retransmit_queue_core #(
	parameter int unsigned DEPTH = arq_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	arq_in_if.sink                         cmd,
	arq_out_if.source                      res,
	input  logic                           cfg_wen,
	input  logic [arq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [arq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// Sequencer state.
	arq_pkg::state_t state_q, state_d;

	// The accepted command. key_q holds the acknowledged sequence number for an
	// acknowledge and the timestamp for a send pass.
	logic [arq_pkg::ACTION_W-1:0] action_q;
	logic [arq_pkg::ID_W-1:0]     recipient_q;
	logic [arq_pkg::REF_W-1:0]    payload_ref_q;
	logic [arq_pkg::LEN_W-1:0]    payload_len_q;
	logic                          once_q;
	logic [arq_pkg::SEQ_W-1:0]    key_q;

	// Configuration and global state.
	logic [arq_pkg::INTERVAL_W-1:0] retry_interval_q;
	logic [arq_pkg::LIMIT_W-1:0]    retry_limit_q;
	logic [arq_pkg::SEQ_W-1:0]      next_seq_q;
	logic [DEPTH-1:0]               valid_q;
	logic [DEPTH-1:0]               visited_q;
	logic [arq_pkg::COUNT_W-1:0]    sent_q;

	// Scan engine: address counter, read stage and the running best candidate.
	logic [IDX_W-1:0]          scan_q;
	logic                      cmp_vld_s1;
	logic [IDX_W-1:0]          cmp_idx_s1;
	logic                      best_found_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic [arq_pkg::SEQ_W-1:0] best_age_q;
	arq_pkg::rec_t             best_rec_q;
	logic                      free_found_q;
	logic [IDX_W-1:0]          free_idx_q;

	// Entry RAM.
	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	arq_pkg::rec_t             ram_wrec;
	logic [arq_pkg::REC_W-1:0] ram_rdata;
	arq_pkg::rec_t             rd_rec;

	// Output register.
	logic          out_vld_q;
	arq_pkg::res_t out_q;
	arq_pkg::res_t out_d;
	logic          out_free;
	logic          out_load;

	// Controls from the output decoder.
	logic             take_input;
	logic             scan_start;
	logic             set_valid;
	logic             clr_valid;
	logic [IDX_W-1:0] vld_idx;
	logic             mark_visited;
	logic             sent_inc;
	logic             seq_adv;

	// Shared comparator and pass arithmetic.
	logic [arq_pkg::SEQ_W-1:0]  rd_age;
	logic                       rd_vld;
	logic                       age_gt;
	logic                       take_best;
	logic                       take_free;
	logic [arq_pkg::SEQ_W-1:0]  new_seq;
	logic [IDX_W-1:0]           enq_slot;
	logic [arq_pkg::ATT_W-1:0]  att_inc;
	logic [arq_pkg::TIME_W-1:0] elapsed;
	logic                       due;
	logic [arq_pkg::LIMIT_W-1:0] limit;
	logic                       retire;
	logic                       unreach;

	arq_ram #(
		.WIDTH (arq_pkg::REC_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wrec),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	assign rd_rec = arq_pkg::rec_t'(ram_rdata);

	// The comparator sees the entry read in the previous cycle. Age is the
	// distance back from the newest sequence number, so the oldest entry has the
	// largest age; a strict compare keeps the lowest index among equal ages.
	assign rd_age = next_seq_q - rd_rec.seq;
	assign rd_vld = valid_q[cmp_idx_s1];
	assign age_gt = !best_found_q || (rd_age > best_age_q);

	always_comb begin
		take_best = 1'b0;
		unique case (action_q)
			arq_pkg::ACT_ENQUEUE: begin
				// Eviction candidate: most attempts, then oldest.
				take_best = rd_vld && (!best_found_q
					|| (rd_rec.attempts > best_rec_q.attempts)
					|| ((rd_rec.attempts == best_rec_q.attempts) && (rd_age > best_age_q)));
			end
			arq_pkg::ACT_ACK: begin
				take_best = rd_vld && (rd_rec.seq == key_q) && age_gt;
			end
			arq_pkg::ACT_PASS: begin
				take_best = rd_vld && !visited_q[cmp_idx_s1] && age_gt;
			end
			default: begin
				take_best = 1'b0;
			end
		endcase
		take_best = take_best && cmp_vld_s1;
	end

	assign take_free = cmp_vld_s1 && (action_q == arq_pkg::ACT_ENQUEUE) && !rd_vld
		&& !free_found_q;

	// Enqueue target and the new sequence number.
	assign new_seq  = next_seq_q + arq_pkg::SEQ_W'(1);
	assign enq_slot = free_found_q ? free_idx_q : best_idx_q;

	// Send pass decision for the selected entry.
	assign att_inc = (best_rec_q.attempts == '1) ? best_rec_q.attempts
		: best_rec_q.attempts + arq_pkg::ATT_W'(1);
	assign elapsed = key_q - best_rec_q.last_time;
	assign due     = (best_rec_q.attempts == '0)
		|| (elapsed >= arq_pkg::TIME_W'(retry_interval_q));
	assign limit   = best_rec_q.once ? arq_pkg::LIMIT_W'(1) : retry_limit_q;
	assign retire  = att_inc >= limit;
	assign unreach = retire && (limit > arq_pkg::LIMIT_W'(1));

	assign out_free  = !out_vld_q || res.ready;
	assign cmd.ready = (state_q == arq_pkg::ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arq_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					if (cmd.action == arq_pkg::ACT_ENQUEUE || cmd.action == arq_pkg::ACT_ACK
						|| cmd.action == arq_pkg::ACT_PASS) begin
						state_d = arq_pkg::ST_SCAN;
					end
				end
			end
			arq_pkg::ST_SCAN: begin
				if (scan_q == LAST_IDX) begin
					state_d = arq_pkg::ST_SCAN_LAST;
				end
			end
			arq_pkg::ST_SCAN_LAST: begin
				state_d = arq_pkg::ST_DECIDE;
			end
			arq_pkg::ST_DECIDE: begin
				unique case (action_q)
					arq_pkg::ACT_ENQUEUE: begin
						state_d = free_found_q ? arq_pkg::ST_ENQ : arq_pkg::ST_EVICT;
					end
					arq_pkg::ACT_ACK: begin
						state_d = arq_pkg::ST_ACK_OUT;
					end
					arq_pkg::ACT_PASS: begin
						state_d = best_found_q ? arq_pkg::ST_PROC : arq_pkg::ST_DONE;
					end
					default: begin
						state_d = arq_pkg::ST_IDLE;
					end
				endcase
			end
			arq_pkg::ST_EVICT: begin
				if (out_free) begin
					state_d = arq_pkg::ST_ENQ;
				end
			end
			arq_pkg::ST_ENQ, arq_pkg::ST_ACK_OUT, arq_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = arq_pkg::ST_IDLE;
				end
			end
			arq_pkg::ST_PROC: begin
				if (!due || out_free) begin
					state_d = arq_pkg::ST_SCAN;
				end
			end
			default: begin
				state_d = arq_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		take_input   = 1'b0;
		scan_start   = 1'b0;
		set_valid    = 1'b0;
		clr_valid    = 1'b0;
		vld_idx      = best_idx_q;
		mark_visited = 1'b0;
		sent_inc     = 1'b0;
		seq_adv      = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = best_idx_q;
		ram_wrec     = best_rec_q;
		out_load     = 1'b0;
		out_d        = '0;
		unique case (state_q)
			arq_pkg::ST_IDLE: begin
				take_input = cmd.valid;
				scan_start = cmd.valid;
			end
			arq_pkg::ST_EVICT: begin
				out_load       = out_free;
				out_d.kind     = arq_pkg::KIND_EVICTED;
				out_d.seq      = best_rec_q.seq;
				out_d.dest     = best_rec_q.dest;
				out_d.slot_ref = best_rec_q.slot;
				out_d.length   = best_rec_q.length;
			end
			arq_pkg::ST_ENQ: begin
				ram_we             = out_free;
				ram_waddr          = enq_slot;
				ram_wrec.seq       = new_seq;
				ram_wrec.dest      = recipient_q;
				ram_wrec.slot      = payload_ref_q;
				ram_wrec.length    = payload_len_q;
				ram_wrec.once      = once_q;
				ram_wrec.attempts  = '0;
				ram_wrec.last_time = '0;
				set_valid          = out_free;
				vld_idx            = enq_slot;
				seq_adv            = out_free;
				out_load           = out_free;
				out_d.kind         = arq_pkg::KIND_ENQUEUED;
				out_d.seq          = new_seq;
				out_d.dest         = recipient_q;
				out_d.slot_ref     = payload_ref_q;
				out_d.length       = payload_len_q;
				out_d.last         = 1'b1;
			end
			arq_pkg::ST_ACK_OUT: begin
				out_load   = out_free;
				out_d.seq  = key_q;
				out_d.last = 1'b1;
				if (best_found_q) begin
					clr_valid      = out_free;
					out_d.kind     = arq_pkg::KIND_ACK_MATCH;
					out_d.dest     = best_rec_q.dest;
					out_d.slot_ref = best_rec_q.slot;
					out_d.length   = best_rec_q.length;
				end else begin
					out_d.kind = arq_pkg::KIND_ACK_MISS;
				end
			end
			arq_pkg::ST_PROC: begin
				mark_visited = !due || out_free;
				scan_start   = !due || out_free;
				if (due) begin
					ram_we             = out_free;
					ram_wrec.attempts  = att_inc;
					ram_wrec.last_time = key_q;
					clr_valid          = out_free && retire;
					sent_inc           = out_free;
					out_load           = out_free;
					out_d.kind         = arq_pkg::KIND_TRANSMIT;
					out_d.seq          = best_rec_q.seq;
					out_d.dest         = best_rec_q.dest;
					out_d.slot_ref     = best_rec_q.slot;
					out_d.length       = best_rec_q.length;
					out_d.retired      = retire;
					out_d.unreachable  = unreach;
				end
			end
			arq_pkg::ST_DONE: begin
				out_load         = out_free;
				out_d.kind       = arq_pkg::KIND_PASS_DONE;
				out_d.sent_count = sent_q;
				out_d.last       = 1'b1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= arq_pkg::ST_IDLE;
			action_q         <= arq_pkg::ACT_ENQUEUE;
			retry_interval_q <= arq_pkg::INTERVAL_W'(arq_pkg::MESSAGE_RETRY_INTERVAL);
			retry_limit_q    <= arq_pkg::LIMIT_W'(arq_pkg::MESSAGE_RETRY_ATTEMPTS);
			next_seq_q       <= '0;
			valid_q          <= '0;
			visited_q        <= '0;
			sent_q           <= '0;
			scan_q           <= '0;
			cmp_vld_s1       <= 1'b0;
			best_found_q     <= 1'b0;
			free_found_q     <= 1'b0;
			out_vld_q        <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wen) begin
				unique case (cfg_index)
					arq_pkg::CFG_RETRY_INTERVAL: retry_interval_q <= cfg_wdata;
					arq_pkg::CFG_RETRY_LIMIT:    retry_limit_q <= cfg_wdata[arq_pkg::LIMIT_W-1:0];
				endcase
			end

			if (take_input) begin
				action_q  <= cmd.action;
				visited_q <= '0;
				sent_q    <= '0;
			end
			if (mark_visited) begin
				visited_q[best_idx_q] <= 1'b1;
			end
			if (sent_inc) begin
				sent_q <= sent_q + arq_pkg::COUNT_W'(1);
			end
			if (seq_adv) begin
				next_seq_q <= new_seq;
			end
			if (set_valid) begin
				valid_q[vld_idx] <= 1'b1;
			end
			if (clr_valid) begin
				valid_q[vld_idx] <= 1'b0;
			end

			cmp_vld_s1 <= (state_q == arq_pkg::ST_SCAN);
			if (scan_start) begin
				scan_q       <= '0;
				best_found_q <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (state_q == arq_pkg::ST_SCAN) begin
					scan_q <= scan_q + IDX_W'(1);
				end
				if (take_best) begin
					best_found_q <= 1'b1;
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take_input) begin
			recipient_q   <= cmd.recipient;
			payload_ref_q <= cmd.payload_ref;
			payload_len_q <= cmd.payload_len;
			once_q        <= cmd.single_shot;
			key_q         <= (cmd.action == arq_pkg::ACT_ACK) ? cmd.ack_seq : cmd.now;
		end
		cmp_idx_s1 <= scan_q;
		if (take_best) begin
			best_idx_q <= cmp_idx_s1;
			best_age_q <= rd_age;
			best_rec_q <= rd_rec;
		end
		if (take_free) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.kind        = out_q.kind;
	assign res.seq         = out_q.seq;
	assign res.dest        = out_q.dest;
	assign res.slot_ref    = out_q.slot_ref;
	assign res.length      = out_q.length;
	assign res.retired     = out_q.retired;
	assign res.unreachable = out_q.unreachable;
	assign res.sent_count  = out_q.sent_count;
	assign res.last        = out_q.last;

	// A real command keeps the command channel closed in the following cycle.
	`ARQ_ASSERT_NXT(a_busy_after_cmd, cmd.valid && cmd.ready && (cmd.action == arq_pkg::ACT_ENQUEUE || cmd.action == arq_pkg::ACT_ACK || cmd.action == arq_pkg::ACT_PASS), !cmd.ready, "command channel open while a command is in progress")

	// Whatever the scan selected is a live entry.
	`ARQ_ASSERT_IMP(a_best_is_live, (state_q == arq_pkg::ST_DECIDE) && best_found_q, valid_q[best_idx_q], "scan selected an empty entry")

	// Eviction is only considered when the table is full.
	`ARQ_ASSERT_IMP(a_evict_when_full, (state_q == arq_pkg::ST_DECIDE) && (action_q == arq_pkg::ACT_ENQUEUE) && !free_found_q, &valid_q, "no free entry found in a table that is not full")

	// The sequence counter moves only when an enqueue commits.
	`ARQ_ASSERT_NXT(a_seq_steady, !seq_adv, $stable(next_seq_q), "sequence counter changed without an enqueue")

endmodule

@@ verif/arq_result_checker.sv @@
// ----------------------------------------------------------------------------
// Retransmission queue result checker
// Watches the command, result and register ports, keeps its own copy of the
// retransmission table and compares every result transfer with the outcome
// that the table predicts, field by field and in order.
// ----------------------------------------------------------------------------
module arq_result_checker #(
	parameter int unsigned DEPTH = arq_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	arq_in_if                                cmd,
	arq_out_if                               res,
	input  logic                             cfg_wen,
	input  logic [arq_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [arq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int unsigned                      errors,
	output int unsigned                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import arq_pkg::*;

	// Shadow copy of the table and of the two registers.
	logic [DEPTH-1:0]        live;
	rec_t                    entries [DEPTH];
	logic [SEQ_W-1:0]        seq_count;
	logic [INTERVAL_W-1:0]   interval_reg;
	logic [LIMIT_W-1:0]      limit_reg;

	res_t                    awaited_events [$];
	int unsigned             mismatch_count;

	// Age in sequence order: the larger, the older.
	function automatic logic [SEQ_W-1:0] age_of(int idx);
		return seq_count - entries[idx].seq;
	endfunction

	function automatic res_t make_event(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
	                                    int idx, logic ret, logic unr,
	                                    logic [COUNT_W-1:0] cnt, logic is_last);
		res_t r;
		r = '0;
		r.kind = kind;
		r.seq  = seq;
		if (idx >= 0) begin
			r.dest     = entries[idx].dest;
			r.slot_ref = entries[idx].slot;
			r.length   = entries[idx].length;
		end
		r.retired     = ret;
		r.unreachable = unr;
		r.sent_count  = cnt;
		r.last        = is_last;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want,
	                           logic [31:0] seq_tag);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h (seq %0d)",
			                          name, got, want, seq_tag));
	endtask

	// Works out the outcome of one command and moves the table on.
	task automatic run_table_command(logic [ACTION_W-1:0] action, logic [ID_W-1:0] recipient,
	                                 logic [REF_W-1:0] payload_ref,
	                                 logic [LEN_W-1:0] payload_len, logic single_shot,
	                                 logic [SEQ_W-1:0] ack_seq, logic [TIME_W-1:0] now);
		int               slot;
		int               pick;
		int               i;
		int               sent;
		logic [DEPTH-1:0] seen;
		logic [TIME_W-1:0] elapsed;
		logic [LIMIT_W-1:0] lim;
		logic             ret;
		slot = -1;
		pick = -1;
		sent = 0;
		seen = '0;
		case (action)
			ACT_ENQUEUE: begin
				for (i = 0; i < DEPTH; i++)
					if (slot < 0 && !live[i])
						slot = i;
				if (slot < 0) begin
					// Full table: the most tried entry goes, the oldest among equals.
					pick = 0;
					for (i = 1; i < DEPTH; i++)
						if (entries[i].attempts > entries[pick].attempts ||
						    (entries[i].attempts == entries[pick].attempts &&
						     age_of(i) > age_of(pick)))
							pick = i;
					awaited_events.push_back(make_event(KIND_EVICTED, entries[pick].seq, pick,
					                                    1'b0, 1'b0, '0, 1'b0));
					live[pick] = 1'b0;
					slot = pick;
				end
				seq_count = seq_count + 1'b1;
				live[slot]               = 1'b1;
				entries[slot].seq        = seq_count;
				entries[slot].dest       = recipient;
				entries[slot].slot       = payload_ref;
				entries[slot].length     = payload_len;
				entries[slot].once       = single_shot;
				entries[slot].attempts   = '0;
				entries[slot].last_time  = '0;
				awaited_events.push_back(make_event(KIND_ENQUEUED, seq_count, slot,
				                                    1'b0, 1'b0, '0, 1'b1));
			end
			ACT_ACK: begin
				for (i = 0; i < DEPTH; i++)
					if (live[i] && entries[i].seq == ack_seq &&
					    (pick < 0 || age_of(i) > age_of(pick)))
						pick = i;
				if (pick >= 0) begin
					awaited_events.push_back(make_event(KIND_ACK_MATCH, ack_seq, pick,
					                                    1'b0, 1'b0, '0, 1'b1));
					live[pick] = 1'b0;
				end else begin
					awaited_events.push_back(make_event(KIND_ACK_MISS, ack_seq, -1,
					                                    1'b0, 1'b0, '0, 1'b1));
				end
			end
			ACT_PASS: begin
				do begin
					pick = -1;
					for (i = 0; i < DEPTH; i++)
						if (live[i] && !seen[i] && (pick < 0 || age_of(i) > age_of(pick)))
							pick = i;
					if (pick >= 0) begin
						seen[pick] = 1'b1;
						elapsed = now - entries[pick].last_time;
						if (entries[pick].attempts == '0 ||
						    elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, interval_reg}) begin
							entries[pick].last_time = now;
							if (entries[pick].attempts != {ATT_W{1'b1}})
								entries[pick].attempts = entries[pick].attempts + 1'b1;
							lim = entries[pick].once ? LIMIT_W'(1) : limit_reg;
							ret = (entries[pick].attempts >= lim);
							awaited_events.push_back(make_event(KIND_TRANSMIT, entries[pick].seq,
							                                    pick, ret,
							                                    ret && (lim > LIMIT_W'(1)),
							                                    '0, 1'b0));
							if (ret)
								live[pick] = 1'b0;
							sent++;
						end
					end
				end while (pick >= 0);
				awaited_events.push_back(make_event(KIND_PASS_DONE, '0, -1, 1'b0, 1'b0,
				                                    COUNT_W'(sent), 1'b1));
			end
			default: begin
			end
		endcase
	endtask

	task automatic compare_event();
		res_t got;
		res_t want;
		got.kind        = res.kind;
		got.seq         = res.seq;
		got.dest        = res.dest;
		got.slot_ref    = res.slot_ref;
		got.length      = res.length;
		got.retired     = res.retired;
		got.unreachable = res.unreachable;
		got.sent_count  = res.sent_count;
		got.last        = res.last;
		if (awaited_events.size() == 0) begin
			report_mismatch($sformatf("result kind %0h seq %0d with nothing outstanding",
			                          got.kind, got.seq));
		end else begin
			want = awaited_events.pop_front();
			check_field("kind", got.kind, want.kind, want.seq);
			check_field("seq", got.seq, want.seq, want.seq);
			check_field("dest", got.dest, want.dest, want.seq);
			check_field("slot_ref", got.slot_ref, want.slot_ref, want.seq);
			check_field("length", got.length, want.length, want.seq);
			check_field("retired", got.retired, want.retired, want.seq);
			check_field("unreachable", got.unreachable, want.unreachable, want.seq);
			check_field("sent_count", got.sent_count, want.sent_count, want.seq);
			check_field("last", got.last, want.last, want.seq);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live           = '0;
			seq_count      = '0;
			interval_reg   = INTERVAL_W'(MESSAGE_RETRY_INTERVAL);
			limit_reg      = LIMIT_W'(MESSAGE_RETRY_ATTEMPTS);
			mismatch_count = 0;
			for (int i = 0; i < DEPTH; i++)
				entries[i] = '0;
			awaited_events.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			// Results belong to older commands, so they are checked first.
			if (res.valid && res.ready)
				compare_event();
			if (cfg_wen) begin
				case (cfg_index)
					CFG_RETRY_INTERVAL: interval_reg = cfg_wdata[INTERVAL_W-1:0];
					CFG_RETRY_LIMIT:    limit_reg    = cfg_wdata[LIMIT_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.valid && cmd.ready)
				run_table_command(cmd.action, cmd.recipient, cmd.payload_ref, cmd.payload_len,
				                  cmd.single_shot, cmd.ack_seq, cmd.now);
			errors  <= mismatch_count;
			pending <= awaited_events.size();
		end
	end

endmodule

@@ verif/tb_ack_retransmit_queue_core.sv @@
// ----------------------------------------------------------------------------
// Retransmission queue testbench
// Drives enqueue, acknowledge and send-pass commands into the queue under
// several register settings and idling patterns; a checker beside the block
// predicts every result and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_ack_retransmit_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	import arq_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEF;

	// The action code that the block has no use for; it must be dropped silently.
	localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

	// A full send pass visits every entry once for each live entry, so twice that
	// figure is ample time for a command that produces nothing to finish.
	localparam int SETTLE_CYCLES = 2 * (DEPTH + 1) * (DEPTH + 3);
	localparam int CYCLE_LIMIT   = 1500000;
	localparam int PHASE_ITEMS   = 64;
	localparam int NUM_PHASES    = 5;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     recipient;
		logic [REF_W-1:0]    payload_ref;
		logic [LEN_W-1:0]    payload_len;
		logic                single_shot;
		logic [SEQ_W-1:0]    ack_seq;
		logic [TIME_W-1:0]   now;
	} cmd_item_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wen;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;
	int unsigned             mismatches;
	int unsigned             outstanding;

	// Stimulus bookkeeping: how many sequence numbers have been handed out, the
	// running timestamp for send passes, and the interval currently in force.
	int unsigned             issued;
	int unsigned             item_count;
	int unsigned             cycle_count;
	logic [TIME_W-1:0]       stamp;
	int unsigned             cur_interval;
	int unsigned             sender_idle_pct;
	int unsigned             receiver_stall_pct;

	arq_in_if  cmd_ch ();
	arq_out_if res_ch ();

	ack_retransmit_queue_core #(
		.DEPTH (DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	arq_result_checker #(
		.DEPTH (DEPTH)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (mismatches),
		.pending   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result side stalls at random; the rate follows the idling pattern that
	// the command side has selected for the current stretch of items.
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// Watchdog: a run that hangs, or that leaves results outstanding for ever,
	// ends here with the failure message.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[ack_retransmit_queue_core] ERROR");
		$finish;
	end

	function automatic cmd_item_t make_cmd(logic [ACTION_W-1:0] action,
	                                       logic [ID_W-1:0] recipient,
	                                       logic [REF_W-1:0] payload_ref,
	                                       logic [LEN_W-1:0] payload_len,
	                                       logic single_shot, logic [SEQ_W-1:0] ack_seq,
	                                       logic [TIME_W-1:0] now);
		cmd_item_t c;
		c.action      = action;
		c.recipient   = recipient;
		c.payload_ref = payload_ref;
		c.payload_len = payload_len;
		c.single_shot = single_shot;
		c.ack_seq     = ack_seq;
		c.now         = now;
		return c;
	endfunction

	// Builds one random command. Fields that the action does not use are filled
	// with noise all the same, since the block must ignore them.
	function automatic cmd_item_t random_command(int unsigned enq_weight);
		cmd_item_t   c;
		int unsigned pick;
		int unsigned lo;
		c.recipient   = $urandom_range(0, 255);
		c.payload_ref = $urandom_range(0, 15);
		c.payload_len = $urandom_range(0, 1024);
		c.single_shot = ($urandom_range(0, 99) < 25);
		c.ack_seq     = $urandom;
		c.now         = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			c.action = ACT_RESERVED;
		end else if (pick < 3 + enq_weight) begin
			c.action = ACT_ENQUEUE;
		end else if ($urandom_range(0, 99) < 45) begin
			c.action = ACT_ACK;
			// Mostly a recent sequence number, so that live entries are hit;
			// otherwise an arbitrary or never issued one.
			pick = $urandom_range(0, 99);
			lo = (issued > 24) ? issued - 24 : 1;
			if (pick < 75 && issued != 0)
				c.ack_seq = $urandom_range(issued, lo);
			else if (pick < 90)
				c.ack_seq = issued + 1;
		end else begin
			c.action = ACT_PASS;
			// Time mostly moves forward by up to twice the retry interval plus two, now and
			// then stands still, and sometimes jumps anywhere, wrapping included.
			pick = $urandom_range(0, 99);
			if (pick < 80)
				stamp = stamp + $urandom_range(0, 2 * cur_interval + 2);
			else if (pick >= 92)
				stamp = $urandom;
			c.now = stamp;
		end
		return c;
	endfunction

	// Presents one command and returns at the falling edge after its transfer.
	// Valid is left high so that a following command can go out back to back;
	// it is lowered only when the sender chooses to idle.
	task automatic send_command(input cmd_item_t c);
		case ((item_count / 20) % 4)
			0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
			1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
			default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
		endcase
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.action      <= c.action;
		cmd_ch.recipient   <= c.recipient;
		cmd_ch.payload_ref <= c.payload_ref;
		cmd_ch.payload_len <= c.payload_len;
		cmd_ch.single_shot <= c.single_shot;
		cmd_ch.ack_seq     <= c.ack_seq;
		cmd_ch.now         <= c.now;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (c.action == ACT_ENQUEUE)
			issued++;
		item_count++;
		@(negedge clk);
	endtask

	// Registers are only written with the block idle: every predicted result has
	// been taken and the settle time has passed in case the last command was one
	// that yields nothing. Both registers are written on consecutive cycles; the
	// upper byte of the limit write carries noise that the block must drop.
	task automatic apply_settings(input logic [INTERVAL_W-1:0] interval,
	                              input logic [LIMIT_W-1:0] limit);
		cmd_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= CFG_RETRY_INTERVAL;
		cfg_wdata <= interval;
		@(negedge clk);
		cfg_index <= CFG_RETRY_LIMIT;
		cfg_wdata <= {CFG_DATA_W'($urandom_range(0, 255)) << LIMIT_W} | CFG_DATA_W'(limit);
		@(negedge clk);
		cfg_wen <= 1'b0;
		cur_interval = interval;
	endtask

	initial begin : stimulus
		cmd_item_t          c;
		int unsigned        counted;
		int unsigned        enq_weight;
		logic [INTERVAL_W-1:0] interval;
		logic [LIMIT_W-1:0]    limit;

		issued             = 0;
		item_count         = 0;
		stamp              = '0;
		cur_interval       = MESSAGE_RETRY_INTERVAL;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		arst_n             = 1'b0;
		cfg_wen            = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.action      = '0;
		cmd_ch.recipient   = '0;
		cmd_ch.payload_ref = '0;
		cmd_ch.payload_len = '0;
		cmd_ch.single_shot = 1'b0;
		cmd_ch.ack_seq     = '0;
		cmd_ch.now         = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, first with the register values left by reset (interval
		// 1000, limit 3). An acknowledge and a pass on the empty table come first.
		send_command(make_cmd(ACT_ACK, 8'd0, 4'd0, 11'd0, 1'b0, 32'd0, 32'd0));
		send_command(make_cmd(ACT_PASS, 8'd0, 4'd0, 11'd0, 1'b0, 32'd0, 32'd0));
		// Field extremes: an acknowledged message with recipient and reference at their top
		// and a length of 1024, and a single-shot one with every field at zero.
		send_command(make_cmd(ACT_ENQUEUE, 8'hFF, 4'hF, 11'd1024, 1'b0, 32'd0, 32'd0));
		send_command(make_cmd(ACT_ENQUEUE, 8'h00, 4'h0, 11'd0, 1'b1, 32'd0, 32'd0));
		// The spare action code with every bit set must be dropped without a result.
		send_command(make_cmd(ACT_RESERVED, 8'hFF, 4'hF, 11'h7FF, 1'b1, 32'hFFFF_FFFF,
		                      32'hFFFF_FFFF));
		// New entries go out at once; the single-shot one retires without being
		// called unreachable.
		send_command(make_cmd(ACT_PASS, 8'd0, 4'd0, 11'd0, 1'b0, 32'd0, 32'd5));
		// Interval not yet elapsed, then elapsed exactly.
		send_command(make_cmd(ACT_PASS, 8'd0, 4'd0, 11'd0, 1'b0, 32'd0, 32'd500));
		send_command(make_cmd(ACT_PASS, 8'd0, 4'd0, 11'd0, 1'b0, 32'd0, 32'd1005));
		// Third attempt reaches the limit: retired and flagged unreachable.
		send_command(make_cmd(ACT_PASS, 8'd0, 4'd0, 11'd0, 1'b0, 32'd0, 32'hFFFF_FFFF));
		// A matched and an unmatched acknowledge.
		send_command(make_cmd(ACT_ENQUEUE, 8'hAA, 4'hA, 11'd683, 1'b0, 32'd0, 32'd0));
		send_command(make_cmd(ACT_ACK, 8'd0, 4'd0, 11'd0, 1'b0, 32'd3, 32'd0));
		send_command(make_cmd(ACT_ACK, 8'd0, 4'd0, 11'd0, 1'b0, 32'hFFFF_FFFF, 32'd0));
		send_command(make_cmd(ACT_ENQUEUE, 8'h55, 4'h5, 11'd341, 1'b0, 32'd0, 32'd0));
		// A limit of zero retires an entry after a single send, with no
		// unreachable flag; an interval of zero makes every entry due.
		apply_settings(16'd0, 8'd0);
		send_command(make_cmd(ACT_PASS, 8'd0, 4'd0, 11'd0, 1'b0, 32'd0, 32'h8000_0000));
		send_command(make_cmd(ACT_ENQUEUE, 8'h3C, 4'h3, 11'd17, 1'b0, 32'd0, 32'd0));
		send_command(make_cmd(ACT_PASS, 8'd0, 4'd0, 11'd0, 1'b0, 32'd0, 32'd0));

		// Random part, one phase per register setting. The phase with the longest
		// interval and highest limit keeps entries alive, so the table fills and
		// eviction by attempt count is exercised.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin interval = 16'd1000;  limit = 8'd3;   enq_weight = 45; end
				1: begin interval = 16'd0;     limit = 8'd1;   enq_weight = 40; end
				2: begin interval = 16'hFFFF;  limit = 8'hFF;  enq_weight = 70; end
				3: begin
					interval   = $urandom_range(1, 3000);
					limit      = $urandom_range(2, 6);
					enq_weight = 50;
				end
				default: begin interval = 16'd50; limit = 8'd2; enq_weight = 45; end
			endcase
			apply_settings(interval, limit);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				c = random_command(enq_weight);
				send_command(c);
				if (c.action != ACT_RESERVED)
					counted++;
			end
		end
		cmd_ch.valid <= 1'b0;

		// Drain: every predicted result must arrive, then nothing more may follow.
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ack_retransmit_queue_core] OK");
		else
			$display("[ack_retransmit_queue_core] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/arq_pkg.sv
hdl/arq_in_if.sv
hdl/arq_out_if.sv
hdl/arq_ram.sv
hdl/ack_retransmit_queue_core.sv
verif/arq_result_checker.sv
verif/tb_ack_retransmit_queue_core.sv
